@@ hw/rtl/rqs_pkg.sv @@
// Shared types, codes and sizes for the priority ready-queue scheduler.
// No dependencies; every other file in hw/rtl uses it by scoped name.
package rqs_pkg;

    localparam int TASK_SLOTS      = 64;
    localparam int PRIORITY_LEVELS = 8;
    localparam int SLOT_W          = 6;
    localparam int LEVEL_W         = 3;
    localparam int MAP_W           = 8;
    localparam int WALK_W          = 7;

    localparam logic [1:0] KIND_ENQ  = 2'd0;
    localparam logic [1:0] KIND_MARK = 2'd1;
    localparam logic [1:0] KIND_POP  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SLOT_W-1:0]  task_slot;
        logic [LEVEL_W-1:0] level;
        logic               ready_bit;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] chosen_slot;
        logic [MAP_W-1:0]  nonempty_levels;
    } t_out_item;

    // Sequencer to level table.
    typedef struct packed {
        logic                       enq;
        logic                       rm;
        logic                       rm_last;
        logic                       sel_cand;
        logic [LEVEL_W-1:0]         level;
        logic [SLOT_W-1:0]          slot;
        logic [PRIORITY_LEVELS-1:0] elig;
    } t_lvl_ctrl;

    // Level table to sequencer.
    typedef struct packed {
        logic [PRIORITY_LEVELS-1:0] occ_now;
        logic [PRIORITY_LEVELS-1:0] occ_next;
        logic                       cand_valid;
        logic [LEVEL_W-1:0]         cand_level;
        logic [SLOT_W-1:0]          rd_head;
        logic [SLOT_W-1:0]          rd_tail;
    } t_lvl_stat;

    // Sequencer to slot store.
    typedef struct packed {
        logic              link_we;
        logic [SLOT_W-1:0] link_waddr;
        logic [SLOT_W-1:0] link_wdata;
        logic              rdy_we;
        logic [SLOT_W-1:0] rdy_waddr;
        logic              rdy_wdata;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } t_store_req;

endpackage

@@ hw/rtl/priority_ready_queue_scheduler.sv @@
// Top level of the priority ready-queue scheduler: command sequencer.
// Depends on rqs_pkg, rqs_slot_store and rqs_level_table.
//
// Commands are accepted at a rising edge where start is high and busy is low;
// every command gives exactly one result beat, shown for one cycle under
// o_valid, and the receiver cannot stall it. Enqueue, ready-mark and the
// unused kind finish at the accepting edge, so their result shows in the
// next cycle and busy never rises: one such command can be taken every
// cycle while no pop holds busy. A pop holds busy while it removes list
// entries, because each removal reads the slot's link and ready mark from
// the slot memories, whose read is registered, before it can rewrite the
// level head. The result beat shows in the first cycle with busy low.
// Levels are scanned from 7 down, entries in FIFO order; stale (not ready)
// entries are dropped on the way.
// No clearing pass is needed after reset: ready marks carry per-slot written
// bits and list links are only read once written.
module priority_ready_queue_scheduler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rqs_pkg::t_in_item i_item,
    output logic              o_valid,
    output rqs_pkg::t_out_item o_result
);

    rqs_pkg::t_state                     r_state, n_state;
    logic [rqs_pkg::PRIORITY_LEVELS-1:0] r_elig, n_elig;
    logic [rqs_pkg::WALK_W-1:0]          r_walk, n_walk;
    logic [rqs_pkg::WALK_W-1:0]          walk_inc;
    logic [rqs_pkg::LEVEL_W-1:0]         r_lvl, n_lvl;
    logic [rqs_pkg::SLOT_W-1:0]          r_head, n_head;
    logic                                r_last, n_last;
    logic                                r_valid, n_valid;
    rqs_pkg::t_out_item                  r_result, n_result;

    rqs_pkg::t_lvl_ctrl  lvl_ctrl;
    rqs_pkg::t_lvl_stat  lvl_stat;
    rqs_pkg::t_store_req store_req;
    logic [rqs_pkg::SLOT_W-1:0] rd_link;
    logic                       rd_ready;
    logic                       accept;

    rqs_slot_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rd_link  (rd_link),
        .o_rd_ready (rd_ready)
    );

    rqs_level_table u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (lvl_ctrl),
        .o_stat  (lvl_stat)
    );

    assign busy     = (r_state != rqs_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign walk_inc = r_walk + rqs_pkg::WALK_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rqs_pkg::ST_IDLE: begin
                if (accept && i_item.kind == rqs_pkg::KIND_POP) begin
                    n_state = rqs_pkg::ST_READ;
                end
            end
            rqs_pkg::ST_READ: begin
                n_state = lvl_stat.cand_valid ? rqs_pkg::ST_EVAL : rqs_pkg::ST_IDLE;
            end
            rqs_pkg::ST_EVAL: begin
                n_state = rd_ready ? rqs_pkg::ST_IDLE : rqs_pkg::ST_READ;
            end
            default: begin
                n_state = rqs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control and result
    always_comb begin
        n_elig    = r_elig;
        n_walk    = r_walk;
        n_lvl     = r_lvl;
        n_head    = r_head;
        n_last    = r_last;
        n_valid   = 1'b0;
        n_result  = '0;
        lvl_ctrl  = '0;
        store_req = '0;
        lvl_ctrl.elig = r_elig;
        case (r_state)
            rqs_pkg::ST_IDLE: begin
                lvl_ctrl.level = i_item.level;
                lvl_ctrl.slot  = i_item.task_slot;
                if (accept) begin
                    case (i_item.kind)
                        rqs_pkg::KIND_ENQ: begin
                            // link the old tail to the new slot if the list is live
                            lvl_ctrl.enq         = 1'b1;
                            store_req.link_we    = lvl_stat.occ_now[i_item.level];
                            store_req.link_waddr = lvl_stat.rd_tail;
                            store_req.link_wdata = i_item.task_slot;
                            n_valid              = 1'b1;
                        end
                        rqs_pkg::KIND_MARK: begin
                            store_req.rdy_we    = 1'b1;
                            store_req.rdy_waddr = i_item.task_slot;
                            store_req.rdy_wdata = i_item.ready_bit;
                            n_valid             = 1'b1;
                        end
                        rqs_pkg::KIND_POP: begin
                            n_elig = '1;
                            n_walk = '0;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            rqs_pkg::ST_READ: begin
                // fetch link and ready mark of the chosen level's head
                lvl_ctrl.sel_cand = 1'b1;
                if (lvl_stat.cand_valid) begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = lvl_stat.rd_head;
                    n_lvl             = lvl_stat.cand_level;
                    n_head            = lvl_stat.rd_head;
                    n_last            = (lvl_stat.rd_head == lvl_stat.rd_tail);
                end else begin
                    n_valid = 1'b1;
                end
            end
            rqs_pkg::ST_EVAL: begin
                // drop the head; return it if ready, otherwise walk on
                lvl_ctrl.rm      = 1'b1;
                lvl_ctrl.rm_last = r_last;
                lvl_ctrl.level   = r_lvl;
                lvl_ctrl.slot    = rd_link;
                if (rd_ready) begin
                    n_valid              = 1'b1;
                    n_result.found       = 1'b1;
                    n_result.chosen_slot = r_head;
                end else if (r_last) begin
                    n_walk = '0;
                end else if (walk_inc == rqs_pkg::WALK_W'(rqs_pkg::TASK_SLOTS)) begin
                    // walk limit reached: leave the rest and move to lower levels
                    n_elig[r_lvl] = 1'b0;
                    n_walk        = '0;
                end else begin
                    n_walk = walk_inc;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
        n_result.nonempty_levels = rqs_pkg::MAP_W'(lvl_stat.occ_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rqs_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elig   <= n_elig;
        r_walk   <= n_walk;
        r_lvl    <= n_lvl;
        r_head   <= n_head;
        r_last   <= n_last;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.found |-> o_result.chosen_slot == '0)
        else $error("result without a found slot carries a non-zero slot");

    a_map_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.nonempty_levels == rqs_pkg::MAP_W'(u_levels.r_occ))
        else $error("reported level map differs from level occupancy");

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rqs_pkg::ST_EVAL |-> $past(r_state) == rqs_pkg::ST_READ)
        else $error("removal evaluated without a preceding memory read");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept) || $past(r_state) != rqs_pkg::ST_IDLE)
        else $error("result beat without an accepted command");

endmodule

@@ hw/rtl/rqs_slot_store.sv @@
// Per-slot storage: next-link memory and ready-mark memory, registered read.
// Depends on rqs_pkg.
module rqs_slot_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rqs_pkg::t_store_req i_req,
    output logic [rqs_pkg::SLOT_W-1:0] o_rd_link,
    output logic                o_rd_ready
);

    logic [rqs_pkg::SLOT_W-1:0]     link_mem [rqs_pkg::TASK_SLOTS];
    logic                           ready_mem [rqs_pkg::TASK_SLOTS];
    logic [rqs_pkg::TASK_SLOTS-1:0] r_written;
    logic [rqs_pkg::SLOT_W-1:0]     r_link_q;
    logic                           r_rdy_q;
    logic                           r_wr_q;

    always_ff @(posedge i_clk) begin
        if (i_req.link_we) begin
            link_mem[i_req.link_waddr] <= i_req.link_wdata;
        end
        if (i_req.rdy_we) begin
            ready_mem[i_req.rdy_waddr] <= i_req.rdy_wdata;
        end
        if (i_req.rd_en) begin
            r_link_q <= link_mem[i_req.rd_addr];
            r_rdy_q  <= ready_mem[i_req.rd_addr];
            r_wr_q   <= r_written[i_req.rd_addr];
        end
    end

    // an unwritten ready mark reads as clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_req.rdy_we) begin
            r_written[i_req.rdy_waddr] <= 1'b1;
        end
    end

    assign o_rd_link  = r_link_q;
    assign o_rd_ready = r_rdy_q & r_wr_q;

endmodule

@@ hw/rtl/rqs_level_table.sv @@
// Per-level list heads, tails and occupancy, plus highest-eligible pick.
// Depends on rqs_pkg.
module rqs_level_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rqs_pkg::t_lvl_ctrl i_ctrl,
    output rqs_pkg::t_lvl_stat o_stat
);

    logic [rqs_pkg::SLOT_W-1:0]          r_head [rqs_pkg::PRIORITY_LEVELS];
    logic [rqs_pkg::SLOT_W-1:0]          r_tail [rqs_pkg::PRIORITY_LEVELS];
    logic [rqs_pkg::PRIORITY_LEVELS-1:0] r_occ;
    logic [rqs_pkg::PRIORITY_LEVELS-1:0] n_occ;
    logic [rqs_pkg::PRIORITY_LEVELS-1:0] avail;
    logic                                cand_valid;
    logic [rqs_pkg::LEVEL_W-1:0]         cand_level;
    logic [rqs_pkg::LEVEL_W-1:0]         rd_level;

    // highest eligible non-empty level wins
    always_comb begin
        avail      = r_occ & i_ctrl.elig;
        cand_valid = 1'b0;
        cand_level = '0;
        for (int i = 0; i < rqs_pkg::PRIORITY_LEVELS; i++) begin
            if (avail[i]) begin
                cand_valid = 1'b1;
                cand_level = rqs_pkg::LEVEL_W'(i);
            end
        end
    end

    assign rd_level = i_ctrl.sel_cand ? cand_level : i_ctrl.level;

    always_comb begin
        n_occ = r_occ;
        if (i_ctrl.enq) begin
            n_occ[i_ctrl.level] = 1'b1;
        end else if (i_ctrl.rm && i_ctrl.rm_last) begin
            n_occ[i_ctrl.level] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.enq) begin
            r_tail[i_ctrl.level] <= i_ctrl.slot;
            if (!r_occ[i_ctrl.level]) begin
                r_head[i_ctrl.level] <= i_ctrl.slot;
            end
        end else if (i_ctrl.rm && !i_ctrl.rm_last) begin
            r_head[i_ctrl.level] <= i_ctrl.slot;
        end
    end

    assign o_stat.occ_now    = r_occ;
    assign o_stat.occ_next   = n_occ;
    assign o_stat.cand_valid = cand_valid;
    assign o_stat.cand_level = cand_level;
    assign o_stat.rd_head    = r_head[rd_level];
    assign o_stat.rd_tail    = r_tail[rd_level];

endmodule
